// ===== rtl/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared types, codes and character helpers for the status-line classifier.
// ----------------------------------------------------------------------------
package hslc_pkg;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
		logic       line_end;
		logic       transfer_ok;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic       line_is_status;
		logic [1:0] verdict;
		logic [9:0] status_code;
		logic       code_valid;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_PREFIX0 = 4'd0,
		PH_PREFIX1 = 4'd1,
		PH_PREFIX2 = 4'd2,
		PH_PREFIX3 = 4'd3,
		PH_PREFIX4 = 4'd4,
		PH_MAJOR   = 4'd5,
		PH_MINOR   = 4'd6,
		PH_CODE    = 4'd7,
		PH_REASON  = 4'd8,
		PH_FAIL    = 4'd9
	} phase_t;

	localparam logic       CMD_BYTE       = 1'b0;
	localparam logic       CMD_FINISH     = 1'b1;
	localparam logic       KIND_LINE      = 1'b0;
	localparam logic       KIND_VERDICT   = 1'b1;
	localparam logic [1:0] VERDICT_OK     = 2'd0;
	localparam logic [1:0] VERDICT_FAIL   = 2'd1;
	localparam logic [1:0] VERDICT_AUTH   = 2'd2;
	localparam logic [9:0] CODE_AUTH      = 10'd401;
	localparam logic [3:0] LEAD_CLIENT    = 4'd4;
	localparam logic [3:0] LEAD_SERVER    = 4'd5;
	localparam logic [2:0] DIGITS_FULL    = 3'd3;
	localparam logic [2:0] DIGITS_SAT     = 3'd4;
	localparam logic [7:0] CH_DOT         = 8'h2E;
	localparam logic [7:0] CH_SPACE       = 8'h20;

	// Expected character of the "HTTP/" prefix at a given position.
	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h48; // H
			3'd1:    ch = 8'h54; // T
			3'd2:    ch = 8'h54; // T
			3'd3:    ch = 8'h50; // P
			default: ch = 8'h2F; // slash
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'd32) : b;
	endfunction

endpackage

// ===== rtl/http_status_line_classifier_core.sv =====
// ----------------------------------------------------------------------------
// http_status_line_classifier_core
// Classifies HTTP header lines byte by byte and gives a request verdict.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and its result is then
//   written to the result register, from which the consumer takes it.
// Throughput: one item per cycle, a single pass from input to result register;
//   a line end or finish item waits while the result register is full and stalled.
// Reset: arst_n clears the grammar state, the kept code and both valid flags.
// ----------------------------------------------------------------------------
module http_status_line_classifier_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  hslc_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output hslc_pkg::out_item_t result
);

	// Input register: holds one accepted item until the parser takes it.
	logic                valid_s1;
	hslc_pkg::in_item_t  item_s1;

	// Result register: holds the finished item until the consumer takes it.
	logic                result_valid_q;
	hslc_pkg::out_item_t result_q;

	logic                present;
	hslc_pkg::out_item_t res;
	logic                advance_s1;

	// The parser consumes the staged item unless it produces a result and the
	// result register is still full and stalled. Bytes without a line end
	// never wait for the output side.
	assign advance_s1 = valid_s1 && (!present || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance_s1;

	hslc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.item    (item_s1),
		.present (present),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload of the input register: no reset needed.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance_s1 && present) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && present)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Line reports always carry a success verdict.
	a_line_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == hslc_pkg::KIND_LINE)
		|-> result.verdict == hslc_pkg::VERDICT_OK)
		else $error("line report with non-success verdict");

	// A code is shown only when it is a valid three-digit code.
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.code_valid |-> result.status_code == 10'd0)
		else $error("status code shown without a valid code");

	// Verdicts never flag the line as a status line.
	a_verdict_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == hslc_pkg::KIND_VERDICT)
		|-> !result.line_is_status)
		else $error("verdict carries a line flag");

	// An empty input register always takes a new item.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but not ready");

endmodule

// ===== rtl/hslc_parser.sv =====
// ----------------------------------------------------------------------------
// hslc_parser
// Per-line grammar state, kept code and result formation for one item.
// ----------------------------------------------------------------------------
module hslc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  hslc_pkg::in_item_t  item,
	output logic                present,
	output hslc_pkg::out_item_t res
);

	hslc_pkg::phase_t phase_q, phase_d, phase_adv;
	logic [2:0] digit_count_q, digit_count_d, digit_adv;
	logic [9:0] code_accum_q, code_accum_d, accum_adv;
	logic [3:0] lead_digit_q, lead_digit_d, lead_adv;
	logic       kept_flag_q, kept_flag_d;
	logic [9:0] kept_code_q, kept_code_d;
	logic [3:0] kept_lead_q, kept_lead_d;
	logic       kept_three_q, kept_three_d;
	logic [7:0] b;
	logic [3:0] d;
	logic       match;
	logic       keep_now;
	logic [1:0] verdict_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hslc_pkg::PH_PREFIX0;
			digit_count_q <= '0;
			code_accum_q  <= '0;
			lead_digit_q  <= '0;
			kept_flag_q   <= 1'b0;
			kept_code_q   <= '0;
			kept_lead_q   <= '0;
			kept_three_q  <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			digit_count_q <= digit_count_d;
			code_accum_q  <= code_accum_d;
			lead_digit_q  <= lead_digit_d;
			kept_flag_q   <= kept_flag_d;
			kept_code_q   <= kept_code_d;
			kept_lead_q   <= kept_lead_d;
			kept_three_q  <= kept_three_d;
		end
	end

	assign b       = item.data_byte;
	assign d       = b[3:0];
	assign present = (item.command == hslc_pkg::CMD_FINISH) || item.line_end;

	// Advance the line grammar by one byte.
	always_comb begin
		phase_adv = phase_q;
		digit_adv = digit_count_q;
		accum_adv = code_accum_q;
		lead_adv  = lead_digit_q;
		unique case (phase_q)
			hslc_pkg::PH_PREFIX0, hslc_pkg::PH_PREFIX1, hslc_pkg::PH_PREFIX2,
			hslc_pkg::PH_PREFIX3, hslc_pkg::PH_PREFIX4: begin
				if (hslc_pkg::to_upper(b) == hslc_pkg::prefix_char(phase_q[2:0]))
					phase_adv = hslc_pkg::phase_t'(phase_q + 4'd1);
				else
					phase_adv = hslc_pkg::PH_FAIL;
			end
			hslc_pkg::PH_MAJOR: begin
				if (!hslc_pkg::is_digit(b))
					phase_adv = (b == hslc_pkg::CH_DOT) ? hslc_pkg::PH_MINOR
						: hslc_pkg::PH_FAIL;
			end
			hslc_pkg::PH_MINOR: begin
				if (!hslc_pkg::is_digit(b))
					phase_adv = (b == hslc_pkg::CH_SPACE) ? hslc_pkg::PH_CODE
						: hslc_pkg::PH_FAIL;
			end
			hslc_pkg::PH_CODE: begin
				if (hslc_pkg::is_digit(b)) begin
					if (digit_count_q == 3'd0)
						lead_adv = d;
					if (digit_count_q < hslc_pkg::DIGITS_FULL)
						accum_adv = (code_accum_q << 3) + (code_accum_q << 1)
							+ {6'd0, d};
					if (digit_count_q < hslc_pkg::DIGITS_SAT)
						digit_adv = digit_count_q + 3'd1;
				end else begin
					phase_adv = (b == hslc_pkg::CH_SPACE) ? hslc_pkg::PH_REASON
						: hslc_pkg::PH_FAIL;
				end
			end
			hslc_pkg::PH_REASON: ;
			default: phase_adv = hslc_pkg::PH_FAIL;
		endcase
	end

	// Next state, keep decision and result fields.
	always_comb begin
		phase_d       = phase_q;
		digit_count_d = digit_count_q;
		code_accum_d  = code_accum_q;
		lead_digit_d  = lead_digit_q;
		kept_flag_d   = kept_flag_q;
		kept_code_d   = kept_code_q;
		kept_lead_d   = kept_lead_q;
		kept_three_d  = kept_three_q;

		match    = (phase_adv == hslc_pkg::PH_REASON);
		keep_now = match && !kept_flag_q && (digit_adv != 3'd0);

		if (!item.transfer_ok)
			verdict_val = hslc_pkg::VERDICT_OK;
		else if (!kept_three_q)
			verdict_val = hslc_pkg::VERDICT_FAIL;
		else if (kept_code_q == hslc_pkg::CODE_AUTH)
			verdict_val = hslc_pkg::VERDICT_AUTH;
		else if ((kept_lead_q == hslc_pkg::LEAD_CLIENT)
				|| (kept_lead_q == hslc_pkg::LEAD_SERVER))
			verdict_val = hslc_pkg::VERDICT_FAIL;
		else
			verdict_val = hslc_pkg::VERDICT_OK;

		if (item.command == hslc_pkg::CMD_FINISH) begin
			res.result_kind    = hslc_pkg::KIND_VERDICT;
			res.line_is_status = 1'b0;
			res.verdict        = verdict_val;
			res.status_code    = kept_three_q ? kept_code_q : 10'd0;
			res.code_valid     = kept_three_q;
		end else begin
			res.result_kind    = hslc_pkg::KIND_LINE;
			res.line_is_status = match;
			res.verdict        = hslc_pkg::VERDICT_OK;
			if (keep_now) begin
				res.status_code = (digit_adv == hslc_pkg::DIGITS_FULL) ? accum_adv : 10'd0;
				res.code_valid  = (digit_adv == hslc_pkg::DIGITS_FULL);
			end else begin
				res.status_code = kept_three_q ? kept_code_q : 10'd0;
				res.code_valid  = kept_three_q;
			end
		end

		if (step) begin
			if (item.command == hslc_pkg::CMD_FINISH) begin
				// Drop the kept code and any partial line.
				phase_d       = hslc_pkg::PH_PREFIX0;
				digit_count_d = '0;
				code_accum_d  = '0;
				lead_digit_d  = '0;
				kept_flag_d   = 1'b0;
				kept_code_d   = '0;
				kept_lead_d   = '0;
				kept_three_d  = 1'b0;
			end else if (item.line_end) begin
				if (keep_now) begin
					kept_flag_d  = 1'b1;
					kept_code_d  = accum_adv;
					kept_lead_d  = lead_adv;
					kept_three_d = (digit_adv == hslc_pkg::DIGITS_FULL);
				end
				phase_d       = hslc_pkg::PH_PREFIX0;
				digit_count_d = '0;
				code_accum_d  = '0;
				lead_digit_d  = '0;
			end else begin
				phase_d       = phase_adv;
				digit_count_d = digit_adv;
				code_accum_d  = accum_adv;
				lead_digit_d  = lead_adv;
			end
		end
	end

endmodule
